// ===== design/lnt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the luma normalized tint block.
// Used by lnt_ctrl, lnt_datapath and the top level luma_normalized_tint.
package lnt_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = 3'd4;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_EMIT    = 1'b1;

	localparam logic ORDER_BGRA = 1'b0;

	localparam logic [9:0] LUMA_WR = 10'd299;
	localparam logic [9:0] LUMA_WG = 10'd587;
	localparam logic [9:0] LUMA_WB = 10'd114;
	localparam logic [9:0] LUMA_ROUND = 10'd500;

	// Reciprocal of 1000 scaled by 2**28, rounded up; exact for sums below 256000.
	localparam logic [18:0] RECIP_1000 = 19'd268436;
	localparam int unsigned RECIP_SHIFT = 28;

	localparam int unsigned DIV_STEPS = 8;
	localparam logic [7:0] LUMA_SAT = 8'hFF;

	typedef struct packed {
		logic load_in;
		logic prod;
		logic sum;
		logic luma;
		logic max_update;
		logic div_start;
		logic div_step;
		logic mul;
		logic alpha;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_emit;
		logic bypass;
	} sts_t;

	// Exact floor(x / 255) for x up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'd1 + 17'(x[15:8]);
		return t[15:8];
	endfunction

endpackage

// ===== design/lnt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the luma normalized tint block: steps one request through the datapath.
// Depends on lnt_pkg for the command and status structs.
module lnt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  lnt_pkg::sts_t sts,
	output lnt_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PROD  = 4'd1;
	localparam logic [3:0] ST_SUM   = 4'd2;
	localparam logic [3:0] ST_LUMA  = 4'd3;
	localparam logic [3:0] ST_UPD   = 4'd4;
	localparam logic [3:0] ST_DIVS  = 4'd5;
	localparam logic [3:0] ST_DIVI  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_ALPHA = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0] state_q, state_d;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				if (sts.is_emit && sts.bypass) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_LUMA;
			end
			ST_LUMA: begin
				cmd.luma = 1'b1;
				state_d = sts.is_emit ? ST_DIVS : ST_UPD;
			end
			ST_UPD: begin
				cmd.max_update = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIVI;
			end
			ST_DIVI: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 3'(lnt_pkg::DIV_STEPS - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ALPHA;
			end
			ST_ALPHA: begin
				cmd.alpha = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.out_load = slot_free;
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/lnt_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the luma normalized tint block: configuration, luma, running maximum,
// restoring divider for normalization, channel scaling and output register. Uses lnt_pkg.
module lnt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lnt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lnt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [31:0]                       in_data,
	input  logic [1:0]                        in_user,
	input  lnt_pkg::cmd_t                     cmd,
	output lnt_pkg::sts_t                     sts,
	output logic [31:0]                       out_data
);

	logic [7:0]  tint_r_q, tint_g_q, tint_b_q;
	logic        byte_order_q, bypass_q;
	logic        op_q, first_q;
	logic [7:0]  sb_q, sg_q, sr_q, sa_q;
	logic [16:0] prod_r_q;
	logic [17:0] prod_g_q;
	logic [14:0] prod_b_q;
	logic [17:0] sum_q;
	logic [36:0] recip_prod;
	logic [7:0]  lum_q, max_q;
	logic [7:0]  divisor;
	logic [15:0] dividend;
	logic [15:0] rem_q, dsh_q;
	logic [7:0]  quo_q;
	logic        sat_q;
	logic [7:0]  nlum;
	logic [15:0] tb_q, tg_q, tr_q;
	logic [15:0] ab_q, ag_q, ar_q;
	logic [7:0]  ob_q, og_q, or_q, oa_q;

	assign sts.is_emit = (op_q == lnt_pkg::OP_EMIT);
	assign sts.bypass  = bypass_q;
	assign out_data    = {oa_q, or_q, og_q, ob_q};

	assign recip_prod = 37'(sum_q) * 37'(lnt_pkg::RECIP_1000);
	assign divisor    = (max_q == 8'd0) ? 8'd1 : max_q;
	assign dividend   = {lum_q, 8'b0} - {8'b0, lum_q};
	assign nlum       = sat_q ? lnt_pkg::LUMA_SAT : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_r_q <= '0;
			tint_g_q <= '0;
			tint_b_q <= '0;
			byte_order_q <= 1'b0;
			bypass_q <= 1'b0;
			max_q <= '0;
			op_q <= lnt_pkg::OP_MEASURE;
			first_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lnt_pkg::CFG_TINT_RED:   tint_r_q <= cfg_data;
					lnt_pkg::CFG_TINT_GREEN: tint_g_q <= cfg_data;
					lnt_pkg::CFG_TINT_BLUE:  tint_b_q <= cfg_data;
					lnt_pkg::CFG_BYTE_ORDER: byte_order_q <= cfg_data[0];
					lnt_pkg::CFG_BYPASS:     bypass_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.load_in) begin
				op_q <= in_user[0];
				first_q <= in_user[1];
			end
			if (cmd.max_update && (first_q || (lum_q > max_q))) begin
				max_q <= lum_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			if (byte_order_q == lnt_pkg::ORDER_BGRA) begin
				sb_q <= in_data[7:0];
				sg_q <= in_data[15:8];
				sr_q <= in_data[23:16];
				sa_q <= in_data[31:24];
			end else begin
				sa_q <= in_data[7:0];
				sb_q <= in_data[15:8];
				sg_q <= in_data[23:16];
				sr_q <= in_data[31:24];
			end
		end
		if (cmd.prod) begin
			prod_r_q <= 17'(sr_q) * 17'(lnt_pkg::LUMA_WR);
			prod_g_q <= 18'(sg_q) * 18'(lnt_pkg::LUMA_WG);
			prod_b_q <= 15'(sb_q) * 15'(lnt_pkg::LUMA_WB);
		end
		if (cmd.sum) begin
			sum_q <= 18'(prod_r_q) + prod_g_q + 18'(prod_b_q) + 18'(lnt_pkg::LUMA_ROUND);
		end
		if (cmd.luma) begin
			lum_q <= recip_prod[lnt_pkg::RECIP_SHIFT+7:lnt_pkg::RECIP_SHIFT];
		end
		if (cmd.div_start) begin
			rem_q <= dividend;
			dsh_q <= {1'b0, divisor, 7'b0};
			quo_q <= '0;
			sat_q <= (dividend >= {divisor, 8'b0});
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				quo_q <= {quo_q[6:0], 1'b0};
			end
			dsh_q <= {1'b0, dsh_q[15:1]};
		end
		if (cmd.mul) begin
			tb_q <= 16'(tint_b_q) * 16'(nlum);
			tg_q <= 16'(tint_g_q) * 16'(nlum);
			tr_q <= 16'(tint_r_q) * 16'(nlum);
		end
		if (cmd.alpha) begin
			ab_q <= 16'(lnt_pkg::div255(tb_q)) * 16'(sa_q);
			ag_q <= 16'(lnt_pkg::div255(tg_q)) * 16'(sa_q);
			ar_q <= 16'(lnt_pkg::div255(tr_q)) * 16'(sa_q);
		end
		if (cmd.out_load) begin
			if (bypass_q) begin
				ob_q <= sb_q;
				og_q <= sg_q;
				or_q <= sr_q;
			end else begin
				ob_q <= lnt_pkg::div255(ab_q);
				og_q <= lnt_pkg::div255(ag_q);
				or_q <= lnt_pkg::div255(ar_q);
			end
			oa_q <= sa_q;
		end
	end

endmodule

// ===== design/luma_normalized_tint.sv =====
`timescale 1ns / 1ps
// Luma normalized tint: one request at a time. A measure request passes the product,
// sum, luma and maximum update steps. An emit loads its result into the output register
// once it is free; a tinted emit first runs the 8-step restoring divider for luma * 255 / max.
// The next request is taken while a result waits in the output register.
// Asynchronous reset clears the tint, byte order, bypass and the running maximum to zero.
module luma_normalized_tint (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// Fields from bit 0: byte0, byte1, byte2, byte3.
	input  logic [31:0]                       s_axis_tdata,
	// Fields from bit 0: operation, first_of_image.
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// Fields from bit 0: out_blue, out_green, out_red, out_alpha.
	output logic [31:0]                       m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [lnt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lnt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	lnt_pkg::cmd_t cmd;
	lnt_pkg::sts_t sts;

	lnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lnt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.prod, cmd.sum, cmd.luma, cmd.max_update,
			cmd.div_start, cmd.div_step, cmd.mul, cmd.alpha, cmd.out_load}))
		else $error("more than one datapath command at once");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register loaded while a result is pending");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request taken while another is in progress");

	a_div_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> cmd.div_step)
		else $error("divider start not followed by iterations");

endmodule
